[hw/rtl/afdl_pkg.sv]
// ----------------------------------------------------------------------------
// afdl_pkg: shared types and constants for the feedback delay line
// Holds field widths, register indexes, reset values and parameter defaults.
// ----------------------------------------------------------------------------
package afdl_pkg;

   // parameter defaults
   localparam int LINE_DEPTH_DEF = 32768;
   localparam int DELAY_UNIT_DEF = 44;

   // field widths
   localparam int SAMPLE_W   = 12;
   localparam int ENTRY_W    = 8;
   localparam int STORE_SHIFT = 4;
   localparam int GAIN_W     = 16;
   localparam int DELAY_W    = 10;
   localparam int PROD_W     = SAMPLE_W + GAIN_W;
   localparam int ACC_W      = PROD_W + 1;
   localparam int FRAC_W     = 15;

   // port widths
   localparam int TDATA_W    = 16;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = '1;

   // register reset values
   localparam logic [GAIN_W-1:0] DRY_GAIN_RST      = 16'd32768;
   localparam logic [GAIN_W-1:0] FEEDBACK_GAIN_RST = 16'd16384;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_EFFECT_ENABLE       = 3'd0,
      CSR_STORE_OUTPUT_MODE   = 3'd1,
      CSR_DELAY_SOURCE_SELECT = 3'd2,
      CSR_PROGRAM_DELAY       = 3'd3,
      CSR_CONTROLLER_DELAY    = 3'd4,
      CSR_DRY_GAIN            = 3'd5,
      CSR_FEEDBACK_GAIN       = 3'd6
   } csr_index_type;

endpackage

[hw/rtl/afdl_offset_calc.sv]
// ----------------------------------------------------------------------------
// afdl_offset_calc: read offset register
// Loads (delay * DELAY_UNIT) mod LINE_DEPTH after reset and after every
// register write. LINE_DEPTH is a power of two: keep the low address bits.
// ----------------------------------------------------------------------------
module afdl_offset_calc #(
   parameter int LINE_DEPTH = afdl_pkg::LINE_DEPTH_DEF,
   parameter int DELAY_UNIT = afdl_pkg::DELAY_UNIT_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic [afdl_pkg::DELAY_W-1:0]        delay,
   output logic                                busy,
   output logic [$clog2(LINE_DEPTH)-1:0]       offset
);

   localparam int ADDR_W   = $clog2(LINE_DEPTH);
   localparam int MAX_PROD = (2**afdl_pkg::DELAY_W - 1) * DELAY_UNIT;
   localparam int PRD_W    = $clog2(MAX_PROD + 1);
   localparam int WK       = (PRD_W > ADDR_W) ? PRD_W : ADDR_W;

   logic              load_ff, load_in;
   logic [WK-1:0]     prod;
   logic [ADDR_W-1:0] offset_ff, offset_in;

   always_comb begin
      load_in   = start;
      prod      = WK'(delay) * WK'(DELAY_UNIT);
      offset_in = offset_ff;
      if (load_ff) begin
         // wrap the distance into the line
         offset_in = prod[ADDR_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         load_ff <= 1'b1;
      end else begin
         load_ff <= load_in;
      end
      offset_ff <= offset_in;
   end

   assign busy   = start || load_ff;
   assign offset = offset_ff;

endmodule

[hw/rtl/audio_feedback_delay_line_core.sv]
// ----------------------------------------------------------------------------
// audio_feedback_delay_line_core: echo / flanger delay line with feedback
// Mixes each sample with an 8-bit entry read a set distance behind the write
// pointer and stores the input or the mix back into the line.
// ----------------------------------------------------------------------------
//
//   channel  dir  handshake              payload
//   req_     in   req_tvalid/req_tready  req_tdata[11:0]  in_sample
//   rsp_     out  rsp_tvalid/rsp_tready  rsp_tdata[11:0]  out_sample
//   csr_     in   csr_write_enable       csr_index, csr_write_data
//
// One beat per cycle sustained unless a result stalls or the read offset reloads:
// memory read at accept, then multiply, mix and write-back; the result register
// loads as the work stage advances. Reset and every register write reload the read
// offset (low bits of delay * DELAY_UNIT, LINE_DEPTH a power of two); input waits.
// No clearing pass: a fill mark and the write pointer make unwritten entries
// read as zero. A stalled result backs up into the work stage, then drops
// req_tready; a read of the entry being written comes from a forwarding register.
//
module audio_feedback_delay_line_core #(
   parameter int LINE_DEPTH = afdl_pkg::LINE_DEPTH_DEF,
   parameter int DELAY_UNIT = afdl_pkg::DELAY_UNIT_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   // request stream
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [afdl_pkg::TDATA_W-1:0]      req_tdata,   // [11:0] in_sample
   // response stream
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [afdl_pkg::TDATA_W-1:0]      rsp_tdata,   // [11:0] out_sample
   // register write port
   input  logic                              csr_write_enable,
   input  logic [afdl_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [afdl_pkg::CSR_DATA_W-1:0]   csr_write_data
);

   localparam int ADDR_W = $clog2(LINE_DEPTH);
   localparam int SW     = afdl_pkg::SAMPLE_W;
   localparam int EW     = afdl_pkg::ENTRY_W;
   localparam int GW     = afdl_pkg::GAIN_W;
   localparam int PW     = afdl_pkg::PROD_W;
   localparam int AW     = afdl_pkg::ACC_W;
   localparam int FW     = afdl_pkg::FRAC_W;
   localparam int RW     = AW - FW;

   // ---------------------------------------------------------------------
   // configuration registers
   // ---------------------------------------------------------------------
   logic                         effect_enable_ff;
   logic                         store_output_mode_ff;
   logic                         delay_source_select_ff;
   logic [afdl_pkg::DELAY_W-1:0] program_delay_ff;
   logic [afdl_pkg::DELAY_W-1:0] controller_delay_ff;
   logic [GW-1:0]                dry_gain_ff;
   logic [GW-1:0]                feedback_gain_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         effect_enable_ff       <= 1'b0;
         store_output_mode_ff   <= 1'b0;
         delay_source_select_ff <= 1'b0;
         program_delay_ff       <= '0;
         controller_delay_ff    <= '0;
         dry_gain_ff            <= afdl_pkg::DRY_GAIN_RST;
         feedback_gain_ff       <= afdl_pkg::FEEDBACK_GAIN_RST;
      end else if (csr_write_enable) begin
         case (csr_index)
            afdl_pkg::CSR_EFFECT_ENABLE: begin
               effect_enable_ff <= csr_write_data[0];
            end
            afdl_pkg::CSR_STORE_OUTPUT_MODE: begin
               store_output_mode_ff <= csr_write_data[0];
            end
            afdl_pkg::CSR_DELAY_SOURCE_SELECT: begin
               delay_source_select_ff <= csr_write_data[0];
            end
            afdl_pkg::CSR_PROGRAM_DELAY: begin
               program_delay_ff <= csr_write_data[afdl_pkg::DELAY_W-1:0];
            end
            afdl_pkg::CSR_CONTROLLER_DELAY: begin
               controller_delay_ff <= csr_write_data[afdl_pkg::DELAY_W-1:0];
            end
            afdl_pkg::CSR_DRY_GAIN: begin
               dry_gain_ff <= csr_write_data[GW-1:0];
            end
            afdl_pkg::CSR_FEEDBACK_GAIN: begin
               feedback_gain_ff <= csr_write_data[GW-1:0];
            end
            default: begin
               // unknown index: drop the write
            end
         endcase
      end
   end

   // delay and effect gate: user holds both fixed with beats in flight; not enforced
   logic [afdl_pkg::DELAY_W-1:0] delay_sel;
   logic                         effect_on;

   assign delay_sel = delay_source_select_ff ? controller_delay_ff : program_delay_ff;
   assign effect_on = effect_enable_ff && (delay_sel != '0);

   // ---------------------------------------------------------------------
   // read offset
   // ---------------------------------------------------------------------
   logic              calc_busy;
   logic [ADDR_W-1:0] back_offset;

   afdl_offset_calc #(
      .LINE_DEPTH (LINE_DEPTH),
      .DELAY_UNIT (DELAY_UNIT)
   ) u_offset_calc (
      .clock  (clock),
      .reset  (reset),
      .start  (csr_write_enable),
      .delay  (delay_sel),
      .busy   (calc_busy),
      .offset (back_offset)
   );

   // ---------------------------------------------------------------------
   // handshake and pipeline control
   // ---------------------------------------------------------------------
   logic s1_valid_ff, s1_valid_in;
   logic out_valid_ff, out_valid_in;
   logic s1_adv;
   logic accept;

   assign s1_adv     = s1_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !calc_busy && (!s1_valid_ff || s1_adv);
   assign accept     = req_tvalid && req_tready;

   assign s1_valid_in  = accept || (s1_valid_ff && !s1_adv);
   assign out_valid_in = s1_adv || (out_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // ---------------------------------------------------------------------
   // write pointer, fill mark and read address
   // ---------------------------------------------------------------------
   logic [ADDR_W-1:0] wp_ff, wp_in;
   logic              full_ff, full_in;
   logic              wp_wrap;
   logic [ADDR_W:0]   addr_diff;
   logic [ADDR_W-1:0] rd_addr;
   logic              rd_written;

   assign wp_wrap   = (wp_ff == ADDR_W'(LINE_DEPTH - 1));
   assign addr_diff = {1'b0, wp_ff} - {1'b0, back_offset};
   // wrap a negative distance back into the line
   assign rd_addr   = addr_diff[ADDR_W]
                    ? ADDR_W'(addr_diff + (ADDR_W+1)'(LINE_DEPTH))
                    : addr_diff[ADDR_W-1:0];
   assign rd_written = full_ff || (rd_addr < wp_ff);

   always_comb begin
      wp_in   = wp_ff;
      full_in = full_ff;
      if (accept && effect_on) begin
         wp_in = wp_wrap ? '0 : wp_ff + ADDR_W'(1);
         if (wp_wrap) begin
            full_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff   <= '0;
         full_ff <= 1'b0;
      end else begin
         wp_ff   <= wp_in;
         full_ff <= full_in;
      end
   end

   // ---------------------------------------------------------------------
   // work stage registers: loaded at accept
   // ---------------------------------------------------------------------
   logic [SW-1:0]     s1_sample_ff;
   logic [PW-1:0]     s1_dry_ff;
   logic              s1_eff_ff;
   logic [ADDR_W-1:0] s1_rd_ff;
   logic [ADDR_W-1:0] s1_wa_ff;
   logic              s1_ok_ff;

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_sample_ff <= req_tdata[SW-1:0];
         s1_dry_ff    <= PW'(req_tdata[SW-1:0]) * PW'(dry_gain_ff);
         s1_eff_ff    <= effect_on;
         s1_rd_ff     <= rd_addr;
         s1_wa_ff     <= wp_ff;
         s1_ok_ff     <= rd_written;
      end
   end

   // ---------------------------------------------------------------------
   // delay line memory and forwarding register
   // ---------------------------------------------------------------------
   logic [EW-1:0]     line_mem [LINE_DEPTH];
   logic [EW-1:0]     rdata_ff;
   logic              commit;
   logic [EW-1:0]     store_val;
   logic              fw_valid_ff;
   logic [ADDR_W-1:0] fw_addr_ff;
   logic [EW-1:0]     fw_data_ff;

   assign commit = s1_adv && s1_eff_ff;

   always_ff @(posedge clock) begin
      if (commit) begin
         line_mem[s1_wa_ff] <= store_val;
      end
      if (accept) begin
         rdata_ff <= line_mem[rd_addr];
      end
   end

   // hold the latest write; a read issued on the same edge misses it
   always_ff @(posedge clock) begin
      if (reset) begin
         fw_valid_ff <= 1'b0;
      end else if (commit) begin
         fw_valid_ff <= 1'b1;
      end
      if (commit) begin
         fw_addr_ff <= s1_wa_ff;
         fw_data_ff <= store_val;
      end
   end

   // ---------------------------------------------------------------------
   // mix and saturate
   // ---------------------------------------------------------------------
   logic [EW-1:0] entry;
   logic [SW-1:0] entry_wide;
   logic [PW-1:0] wet_prod;
   logic [AW-1:0] acc;
   logic [RW-1:0] res_full;
   logic [SW-1:0] res;
   logic [SW-1:0] store_src;

   always_comb begin
      if (fw_valid_ff && (fw_addr_ff == s1_rd_ff)) begin
         entry = fw_data_ff;
      end else if (s1_ok_ff) begin
         entry = rdata_ff;
      end else begin
         // never written since reset: reads as zero
         entry = '0;
      end
      entry_wide = {entry, afdl_pkg::STORE_SHIFT'(0)};
      wet_prod   = PW'(entry_wide) * PW'(feedback_gain_ff);
      acc        = AW'(s1_dry_ff) + AW'(wet_prod);
      res_full   = acc[AW-1:FW];
      res        = (res_full > RW'(afdl_pkg::SAMPLE_MAX)) ? afdl_pkg::SAMPLE_MAX
                                                          : res_full[SW-1:0];
      store_src  = store_output_mode_ff ? res : s1_sample_ff;
      store_val  = store_src[SW-1:afdl_pkg::STORE_SHIFT];
   end

   // ---------------------------------------------------------------------
   // result register
   // ---------------------------------------------------------------------
   logic [SW-1:0] out_data_ff;

   always_ff @(posedge clock) begin
      if (s1_adv) begin
         out_data_ff <= s1_eff_ff ? res : s1_sample_ff;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = afdl_pkg::TDATA_W'(out_data_ff);

endmodule
